### sv/ntps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ntps_pkg;

	localparam int CW     = 32;
	localparam int EW     = 33;
	localparam int MW     = 33;
	localparam int PW     = 66;
	localparam int ACC_W  = 68;
	localparam int NUM_W  = 52;
	localparam int WT_W   = 17;
	localparam int QBITS  = 16;
	localparam int DIST_W = 50;

	localparam logic [WT_W-1:0] ONE_Q16     = 17'd65536;
	localparam logic [1:0]      CORNER_LAST = 2'd2;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [CW-1:0]    coord_t;
	typedef logic signed [EW-1:0]    edge_t;
	typedef logic signed [NUM_W-1:0] num_t;
	typedef logic [WT_W-1:0]         wt_t;

	localparam acc_t SAT_HI = acc_t'(64'sd2147483647);
	localparam acc_t SAT_LO = acc_t'(-64'sd2147483648);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic         operation;
		logic [7:0]   tri_slot;
		logic [1:0]   corner;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
	} item_t;

	typedef struct packed {
		logic         found;
		logic [7:0]   best_tri;
		logic [16:0]  weight_a;
		logic [16:0]  weight_b;
		logic [16:0]  weight_c;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic signed [31:0] offset_z;
	} result_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_CLR,
		DP_FETCH,
		DP_VEC,
		DP_DOT,
		DP_CROSS,
		DP_DECIDE,
		DP_DIV,
		DP_POINT,
		DP_DIST,
		DP_CMP
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] hi;
		logic [1:0] lo;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic need_div;
		logic interior;
	} dp_stat_t;

	typedef enum logic [2:0] {
		ZN_A,
		ZN_B,
		ZN_C,
		ZN_AB,
		ZN_AC,
		ZN_BC,
		ZN_IN
	} zone_t;

	function automatic coord_t sat32(input acc_t x);
		coord_t r;
		if (x > SAT_HI) begin
			r = coord_t'(SAT_HI);
		end else if (x < SAT_LO) begin
			r = coord_t'(SAT_LO);
		end else begin
			r = coord_t'(x);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/ntps_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ntps_ram #(
	parameter int W = 32,
	parameter int D = 768,
	localparam int AW = $clog2(D)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic [W-1:0]       rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### sv/ntps_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ntps_div
	import ntps_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire num_t num,
	input  wire num_t den,
	output logic      done,
	output wt_t       quo
);

	logic             run_q;
	logic             done_q;
	logic [4:0]       cnt_q;
	logic [NUM_W:0]   rem_q;
	logic [NUM_W:0]   dvs_q;
	wt_t              quo_q;
	num_t             nn;
	num_t             nd;
	logic [NUM_W:0]   rem2;

	assign nn   = den[NUM_W-1] ? -num : num;
	assign nd   = den[NUM_W-1] ? -den : den;
	assign rem2 = {rem_q[NUM_W-1:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0 || nn <= 0 || nn >= nd) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
					cnt_q <= 5'(QBITS);
				end
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (NUM_W+1)'(nn);
			dvs_q <= (NUM_W+1)'(nd);
			if (den == '0 || nn <= 0) begin
				quo_q <= '0;
			end else if (nn >= nd) begin
				quo_q <= ONE_Q16;
			end else begin
				quo_q <= '0;
			end
		end else if (run_q) begin
			if (rem2 >= dvs_q) begin
				rem_q <= rem2 - dvs_q;
				quo_q <= {quo_q[WT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem2;
				quo_q <= {quo_q[WT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

### sv/ntps_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ntps_dp
	import ntps_pkg::*;
#(
	parameter int MAX_TRIS = 256,
	localparam int TRI_W = $clog2(MAX_TRIS + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dp_cmd_t          cmd,
	input  wire logic [TRI_W-1:0] tri_idx,
	input  wire item_t            item,
	output dp_stat_t              stat,
	output result_t               res
);

	localparam int DEPTH = MAX_TRIS * 3;
	localparam int AW    = $clog2(DEPTH);

	coord_t p_q [3];
	coord_t a_q [3];
	coord_t b_q [3];
	coord_t c_q [3];
	edge_t  ab_q [3];
	edge_t  ac_q [3];
	edge_t  bc_q [3];
	coord_t sab_q [3];
	coord_t sac_q [3];
	coord_t sap_q [3];
	coord_t sbp_q [3];
	coord_t scp_q [3];
	coord_t d_q [6];
	acc_t   va_q;
	acc_t   vb_q;
	acc_t   vc_q;
	zone_t  zone_q;
	num_t   num1_q;
	num_t   num2_q;
	num_t   den_q;
	wt_t    r1_q;
	wt_t    r2_q;
	logic   sel_q;
	acc_t   acc_q;
	coord_t off_q [3];
	logic [DIST_W-1:0] dist_q;
	logic   found_q;
	logic [DIST_W-1:0] best_d_q;
	logic [7:0] best_tri_q;
	wt_t    best_w_q [3];
	coord_t best_o_q [3];

	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [1:0]    rd_corner;
	coord_t        rd [3];

	logic signed [MW-1:0] mul_a;
	logic signed [MW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	acc_t                 term;
	acc_t                 acc_base;
	acc_t                 acc_sum;
	acc_t                 pt_full;

	zone_t zone_n;
	num_t  num1_n;
	num_t  num2_n;
	num_t  den_n;
	num_t  dn [6];
	num_t  e43;
	num_t  e56;

	wt_t    wa;
	wt_t    wb;
	wt_t    wc;
	wt_t    w1;
	wt_t    w2;
	coord_t org [3];
	edge_t  e1 [3];
	edge_t  e2 [3];
	logic [WT_W:0] in_sum;

	logic div_start;
	logic div_done;
	wt_t  div_quo;

	assign we = (cmd.op == DP_LOAD) && (32'(item.tri_slot) < MAX_TRIS)
		&& (item.corner <= CORNER_LAST);
	assign waddr = AW'(32'(item.tri_slot) * 3 + 32'(item.corner));
	assign rd_corner = (cmd.hi < 3'd3) ? cmd.hi[1:0] : 2'd0;
	assign raddr = AW'(32'(tri_idx) * 3 + 32'(rd_corner));

	ntps_ram #(.W(CW), .D(DEPTH)) u_ram_x (
		.clk(clk), .we(we), .waddr(waddr), .wdata(item.coord_x),
		.raddr(raddr), .rdata(rd[0])
	);
	ntps_ram #(.W(CW), .D(DEPTH)) u_ram_y (
		.clk(clk), .we(we), .waddr(waddr), .wdata(item.coord_y),
		.raddr(raddr), .rdata(rd[1])
	);
	ntps_ram #(.W(CW), .D(DEPTH)) u_ram_z (
		.clk(clk), .we(we), .waddr(waddr), .wdata(item.coord_z),
		.raddr(raddr), .rdata(rd[2])
	);

	// weights and point terms per zone
	always_comb begin
		in_sum = (WT_W+1)'(r1_q) + (WT_W+1)'(r2_q);
		wa = '0;
		wb = '0;
		wc = '0;
		w1 = '0;
		w2 = '0;
		for (int i = 0; i < 3; i++) begin
			org[i] = a_q[i];
			e1[i]  = ab_q[i];
			e2[i]  = ac_q[i];
		end
		case (zone_q)
			ZN_A: begin
				wa = ONE_Q16;
			end
			ZN_B: begin
				wb = ONE_Q16;
				for (int i = 0; i < 3; i++) org[i] = b_q[i];
			end
			ZN_C: begin
				wc = ONE_Q16;
				for (int i = 0; i < 3; i++) org[i] = c_q[i];
			end
			ZN_AB: begin
				wa = ONE_Q16 - r1_q;
				wb = r1_q;
				w1 = r1_q;
			end
			ZN_AC: begin
				wa = ONE_Q16 - r1_q;
				wc = r1_q;
				w1 = r1_q;
				for (int i = 0; i < 3; i++) e1[i] = ac_q[i];
			end
			ZN_BC: begin
				wb = ONE_Q16 - r1_q;
				wc = r1_q;
				w1 = r1_q;
				for (int i = 0; i < 3; i++) begin
					org[i] = b_q[i];
					e1[i]  = bc_q[i];
				end
			end
			ZN_IN: begin
				wa = (in_sum >= (WT_W+1)'(ONE_Q16)) ? '0 : ONE_Q16 - WT_W'(in_sum);
				wb = r1_q;
				wc = r2_q;
				w1 = r1_q;
				w2 = r2_q;
			end
			default: begin
				wa = ONE_Q16;
			end
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			DP_DOT: begin
				mul_a = MW'(cmd.hi[0] ? sac_q[cmd.lo] : sab_q[cmd.lo]);
				case (cmd.hi[2:1])
					2'd0:    mul_b = MW'(sap_q[cmd.lo]);
					2'd1:    mul_b = MW'(sbp_q[cmd.lo]);
					default: mul_b = MW'(scp_q[cmd.lo]);
				endcase
			end
			DP_CROSS: begin
				case (cmd.hi)
					3'd0: begin mul_a = MW'(d_q[0]); mul_b = MW'(d_q[3]); end
					3'd1: begin mul_a = MW'(d_q[2]); mul_b = MW'(d_q[1]); end
					3'd2: begin mul_a = MW'(d_q[4]); mul_b = MW'(d_q[1]); end
					3'd3: begin mul_a = MW'(d_q[0]); mul_b = MW'(d_q[5]); end
					3'd4: begin mul_a = MW'(d_q[2]); mul_b = MW'(d_q[5]); end
					default: begin mul_a = MW'(d_q[4]); mul_b = MW'(d_q[3]); end
				endcase
			end
			DP_POINT: begin
				mul_a = cmd.lo[0] ? e2[cmd.hi[1:0]] : e1[cmd.hi[1:0]];
				mul_b = $signed(MW'(cmd.lo[0] ? w2 : w1));
			end
			DP_DIST: begin
				mul_a = MW'(off_q[cmd.lo]);
				mul_b = MW'(off_q[cmd.lo]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign term     = ACC_W'(prod >>> 16);
	assign acc_base = (cmd.lo == 2'd0) ? '0 : acc_q;
	assign acc_sum  = acc_base + term;
	assign pt_full  = acc_q + term;

	// zone tests
	always_comb begin
		for (int i = 0; i < 6; i++) dn[i] = NUM_W'(d_q[i]);
		e43    = dn[3] - dn[2];
		e56    = dn[4] - dn[5];
		zone_n = ZN_IN;
		num1_n = NUM_W'(vb_q >>> 16);
		num2_n = NUM_W'(vc_q >>> 16);
		den_n  = NUM_W'(vb_q >>> 16) + NUM_W'(vc_q >>> 16) + NUM_W'(va_q >>> 16);
		if (d_q[0] <= 0 && d_q[1] <= 0) begin
			zone_n = ZN_A;
		end else if (d_q[2] >= 0 && d_q[3] <= d_q[2]) begin
			zone_n = ZN_B;
		end else if (vc_q <= 0 && d_q[0] >= 0 && d_q[2] <= 0) begin
			zone_n = ZN_AB;
			num1_n = dn[0];
			den_n  = dn[0] - dn[2];
		end else if (d_q[5] >= 0 && d_q[4] <= d_q[5]) begin
			zone_n = ZN_C;
		end else if (vb_q <= 0 && d_q[1] >= 0 && d_q[5] <= 0) begin
			zone_n = ZN_AC;
			num1_n = dn[1];
			den_n  = dn[1] - dn[5];
		end else if (va_q <= 0 && e43 >= 0 && e56 >= 0) begin
			zone_n = ZN_BC;
			num1_n = e43;
			den_n  = e43 + e56;
		end
	end

	assign div_start = (cmd.op == DP_DIV);

	ntps_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(cmd.lo[0] ? num2_q : num1_q),
		.den(den_q),
		.done(div_done),
		.quo(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.op == DP_CLR) begin
			found_q <= 1'b0;
		end else if (cmd.op == DP_CMP) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			if (sel_q) begin
				r2_q <= div_quo;
			end else begin
				r1_q <= div_quo;
			end
		end
		case (cmd.op)
			DP_CLR: begin
				p_q[0] <= item.coord_x;
				p_q[1] <= item.coord_y;
				p_q[2] <= item.coord_z;
				best_tri_q <= '0;
				best_d_q   <= '0;
				for (int i = 0; i < 3; i++) begin
					best_w_q[i] <= '0;
					best_o_q[i] <= '0;
				end
			end
			DP_FETCH: begin
				case (cmd.hi)
					3'd1: for (int i = 0; i < 3; i++) a_q[i] <= rd[i];
					3'd2: for (int i = 0; i < 3; i++) b_q[i] <= rd[i];
					3'd3: for (int i = 0; i < 3; i++) c_q[i] <= rd[i];
					default: ;
				endcase
			end
			DP_VEC: begin
				for (int i = 0; i < 3; i++) begin
					ab_q[i]  <= EW'(b_q[i]) - EW'(a_q[i]);
					ac_q[i]  <= EW'(c_q[i]) - EW'(a_q[i]);
					bc_q[i]  <= EW'(c_q[i]) - EW'(b_q[i]);
					sab_q[i] <= sat32(ACC_W'(b_q[i]) - ACC_W'(a_q[i]));
					sac_q[i] <= sat32(ACC_W'(c_q[i]) - ACC_W'(a_q[i]));
					sap_q[i] <= sat32(ACC_W'(p_q[i]) - ACC_W'(a_q[i]));
					sbp_q[i] <= sat32(ACC_W'(p_q[i]) - ACC_W'(b_q[i]));
					scp_q[i] <= sat32(ACC_W'(p_q[i]) - ACC_W'(c_q[i]));
				end
			end
			DP_DOT: begin
				acc_q <= acc_sum;
				if (cmd.lo == 2'd2) begin
					d_q[cmd.hi] <= sat32(acc_sum);
				end
			end
			DP_CROSS: begin
				if (!cmd.hi[0]) begin
					acc_q <= ACC_W'(prod);
				end else begin
					case (cmd.hi[2:1])
						2'd0:    vc_q <= acc_q - ACC_W'(prod);
						2'd1:    vb_q <= acc_q - ACC_W'(prod);
						default: va_q <= acc_q - ACC_W'(prod);
					endcase
				end
			end
			DP_DECIDE: begin
				zone_q <= zone_n;
				num1_q <= num1_n;
				num2_q <= num2_n;
				den_q  <= den_n;
			end
			DP_DIV: begin
				sel_q <= cmd.lo[0];
			end
			DP_POINT: begin
				if (!cmd.lo[0]) begin
					acc_q <= ACC_W'(org[cmd.hi[1:0]]) + term;
				end else begin
					off_q[cmd.hi[1:0]] <= sat32(ACC_W'(p_q[cmd.hi[1:0]]) - pt_full);
				end
			end
			DP_DIST: begin
				acc_q <= acc_sum;
				if (cmd.lo == 2'd2) begin
					dist_q <= DIST_W'(acc_sum);
				end
			end
			DP_CMP: begin
				if (!found_q || dist_q < best_d_q) begin
					best_d_q    <= dist_q;
					best_tri_q  <= 8'(tri_idx);
					best_w_q[0] <= wa;
					best_w_q[1] <= wb;
					best_w_q[2] <= wc;
					for (int i = 0; i < 3; i++) best_o_q[i] <= off_q[i];
				end
			end
			default: ;
		endcase
	end

	assign stat.div_done = div_done;
	assign stat.need_div = (zone_q == ZN_AB) || (zone_q == ZN_AC) || (zone_q == ZN_BC)
		|| (zone_q == ZN_IN);
	assign stat.interior = (zone_q == ZN_IN);

	assign res.found    = found_q;
	assign res.best_tri = best_tri_q;
	assign res.weight_a = best_w_q[0];
	assign res.weight_b = best_w_q[1];
	assign res.weight_c = best_w_q[2];
	assign res.offset_x = best_o_q[0];
	assign res.offset_y = best_o_q[1];
	assign res.offset_z = best_o_q[2];

	edge_case_weights: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_CMP) |-> ((wa <= ONE_Q16) && (wb <= ONE_Q16) && (wc <= ONE_Q16)))
		else $error("weight above one");
	div_only_when_needed: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> stat.need_div)
		else $error("divide started without edge or interior zone");
	second_div_interior: assert property (@(posedge clk) disable iff (!arst_n)
		(div_start && cmd.lo[0]) |-> stat.interior)
		else $error("second divide outside interior");

endmodule
`default_nettype wire

### sv/ntps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ntps_ctrl
	import ntps_pkg::*;
#(
	parameter int MAX_TRIS = 256,
	localparam int TRI_W = $clog2(MAX_TRIS + 1)
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic       op_query,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [8:0] cfg_data,
	output dp_cmd_t         cmd,
	output logic [TRI_W-1:0] tri_idx,
	input  wire dp_stat_t   stat,
	output logic            result_valid
);

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b0000_0000_0001,
		ST_FETCH  = 12'b0000_0000_0010,
		ST_VECS   = 12'b0000_0000_0100,
		ST_DOTS   = 12'b0000_0000_1000,
		ST_CROSS  = 12'b0000_0001_0000,
		ST_DECIDE = 12'b0000_0010_0000,
		ST_DIVS   = 12'b0000_0100_0000,
		ST_DIVW   = 12'b0000_1000_0000,
		ST_POINT  = 12'b0001_0000_0000,
		ST_DIST   = 12'b0010_0000_0000,
		ST_CMP    = 12'b0100_0000_0000,
		ST_DONE   = 12'b1000_0000_0000
	} state_t;

	state_t           state_q;
	logic [2:0]       hi_q;
	logic [1:0]       lo_q;
	logic [TRI_W-1:0] tri_q;
	logic [TRI_W-1:0] lim_q;
	logic [TRI_W-1:0] lim_n;
	logic             second_q;
	logic [8:0]       tri_count_q;
	logic             accept;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign lim_n     = (32'(tri_count_q) >= MAX_TRIS) ? TRI_W'(MAX_TRIS)
		: TRI_W'(tri_count_q);
	assign tri_idx      = tri_q;
	assign result_valid = (state_q == ST_DONE);

	always_comb begin
		cmd.op = DP_NOP;
		cmd.hi = hi_q;
		cmd.lo = lo_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.op = op_query ? DP_CLR : DP_LOAD;
				end
			end
			ST_FETCH:  cmd.op = DP_FETCH;
			ST_VECS:   cmd.op = DP_VEC;
			ST_DOTS:   cmd.op = DP_DOT;
			ST_CROSS:  cmd.op = DP_CROSS;
			ST_DECIDE: cmd.op = DP_DECIDE;
			ST_DIVS: begin
				if (stat.need_div) begin
					cmd.op = DP_DIV;
					cmd.lo = {1'b0, second_q};
				end
			end
			ST_POINT:  cmd.op = DP_POINT;
			ST_DIST:   cmd.op = DP_DIST;
			ST_CMP:    cmd.op = DP_CMP;
			default:   cmd.op = DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hi_q        <= '0;
			lo_q        <= '0;
			tri_q       <= '0;
			lim_q       <= '0;
			second_q    <= 1'b0;
			tri_count_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tri_count_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && op_query) begin
						lim_q <= lim_n;
						tri_q <= '0;
						hi_q  <= '0;
						lo_q  <= '0;
						state_q <= (lim_n == '0) ? ST_DONE : ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (hi_q == 3'd3) begin
						hi_q    <= '0;
						state_q <= ST_VECS;
					end else begin
						hi_q <= hi_q + 3'd1;
					end
				end
				ST_VECS: begin
					hi_q    <= '0;
					lo_q    <= '0;
					state_q <= ST_DOTS;
				end
				ST_DOTS: begin
					if (lo_q == 2'd2) begin
						lo_q <= '0;
						if (hi_q == 3'd5) begin
							hi_q    <= '0;
							state_q <= ST_CROSS;
						end else begin
							hi_q <= hi_q + 3'd1;
						end
					end else begin
						lo_q <= lo_q + 2'd1;
					end
				end
				ST_CROSS: begin
					if (hi_q == 3'd5) begin
						hi_q    <= '0;
						state_q <= ST_DECIDE;
					end else begin
						hi_q <= hi_q + 3'd1;
					end
				end
				ST_DECIDE: begin
					second_q <= 1'b0;
					state_q  <= ST_DIVS;
				end
				ST_DIVS: begin
					hi_q <= '0;
					lo_q <= '0;
					state_q <= stat.need_div ? ST_DIVW : ST_POINT;
				end
				ST_DIVW: begin
					if (stat.div_done) begin
						if (stat.interior && !second_q) begin
							second_q <= 1'b1;
							state_q  <= ST_DIVS;
						end else begin
							state_q <= ST_POINT;
						end
					end
				end
				ST_POINT: begin
					if (lo_q == 2'd1) begin
						lo_q <= '0;
						if (hi_q == 3'd2) begin
							hi_q    <= '0;
							state_q <= ST_DIST;
						end else begin
							hi_q <= hi_q + 3'd1;
						end
					end else begin
						lo_q <= lo_q + 2'd1;
					end
				end
				ST_DIST: begin
					if (lo_q == 2'd2) begin
						lo_q    <= '0;
						state_q <= ST_CMP;
					end else begin
						lo_q <= lo_q + 2'd1;
					end
				end
				ST_CMP: begin
					hi_q <= '0;
					lo_q <= '0;
					if (TRI_W'(tri_q + 1'b1) == lim_q) begin
						state_q <= ST_DONE;
					end else begin
						tri_q   <= tri_q + 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	strobe_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");
	fetch_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> (tri_q < lim_q))
		else $error("triangle index past limit");
	done_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == ST_DIVW))
		else $error("divide finished outside wait state");
	empty_query: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_query && tri_count_q == '0) |=> (state_q == ST_DONE))
		else $error("empty query did not finish at once");

endmodule
`default_nettype wire

### sv/nearest_triangle_point_search.sv
`timescale 1ns / 1ps
`default_nettype none
// Nearest point on a set of stored triangles.
// Input: item is taken on a clock edge with start high and busy low.
//   operation 0 writes one corner (x, y, z) of triangle tri_slot in the
//   same cycle and busy stays low. operation 1 queries a point.
// Config: cfg_data (triangle count) is written when cfg_valid and
//   cfg_ready are high; cfg_ready is high while idle.
// Result: one beat per query on result, with result_valid high for one
//   cycle; the receiver has no way to hold it, so it must sample it then.
// Search: each triangle searched takes fetches from the corner memories,
//   33 multiply steps on one shared 33x33 multiplier, setup, zone decision
//   and compare steps, and 0, 1 or 2 runs of a 16-step radix-2 divider.
// Throughput: one query at a time; busy is high for the whole search.
// Reset: clears the triangle count and the sequencer; corner memories are
//   not cleared and hold no meaning until loaded.
module nearest_triangle_point_search
	import ntps_pkg::*;
#(
	parameter int MAX_TRIS = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire item_t      item,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [8:0] cfg_data,
	output logic            result_valid,
	output result_t         result
);

	localparam int TRI_W = $clog2(MAX_TRIS + 1);

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [TRI_W-1:0] tri_idx;

	ntps_ctrl #(.MAX_TRIS(MAX_TRIS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op_query(item.operation == OP_QUERY),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.tri_idx(tri_idx),
		.stat(stat),
		.result_valid(result_valid)
	);

	ntps_dp #(.MAX_TRIS(MAX_TRIS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.tri_idx(tri_idx),
		.item(item),
		.stat(stat),
		.res(result)
	);

endmodule
`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
module tb;
	import ntps_pkg::*;

	localparam int NTRI = 256;

	class nearest_board;
		result_t pending[$];
		int errors;
		int checked;
		longint corner_mem[NTRI][3][3];
		int unsigned count;

		function new();
			errors = 0;
			checked = 0;
			count = 0;
		endfunction

		static function longint floor16(longint x);
			return x >>> 16;
		endfunction

		static function longint clamp32(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		static function longint dot3(longint x[3], longint y[3]);
			return clamp32(floor16(x[0] * y[0]) + floor16(x[1] * y[1]) + floor16(x[2] * y[2]));
		endfunction

		static function longint quotient(longint num, longint den);
			longint rem, q;
			q = 0;
			if (den == 0) return 0;
			if (den < 0) begin
				num = -num;
				den = -den;
			end
			if (num <= 0) return 0;
			if (num >= den) return 65536;
			rem = num;
			for (int i = 0; i < 16; i++) begin
				rem = rem <<< 1;
				q = q <<< 1;
				if (rem >= den) begin
					rem -= den;
					q |= 1;
				end
			end
			return q;
		endfunction

		function void nearest_on_tri(longint p[3], int t, output longint wt[3],
				output longint pt[3]);
			longint a[3], b[3], c[3], ab[3], ac[3], bc[3];
			longint sab[3], sac[3], sap[3], sbp[3], scp[3];
			longint d1, d2, d3, d4, d5, d6, va, vb, vc, v, w, den, wa;
			for (int i = 0; i < 3; i++) begin
				a[i] = corner_mem[t][0][i];
				b[i] = corner_mem[t][1][i];
				c[i] = corner_mem[t][2][i];
			end
			for (int i = 0; i < 3; i++) begin
				ab[i] = b[i] - a[i];
				ac[i] = c[i] - a[i];
				bc[i] = c[i] - b[i];
				sab[i] = clamp32(ab[i]);
				sac[i] = clamp32(ac[i]);
				sap[i] = clamp32(p[i] - a[i]);
				sbp[i] = clamp32(p[i] - b[i]);
				scp[i] = clamp32(p[i] - c[i]);
			end
			d1 = dot3(sab, sap);
			d2 = dot3(sac, sap);
			if (d1 <= 0 && d2 <= 0) begin
				wt = '{65536, 0, 0};
				pt = a;
				return;
			end
			d3 = dot3(sab, sbp);
			d4 = dot3(sac, sbp);
			if (d3 >= 0 && d4 <= d3) begin
				wt = '{0, 65536, 0};
				pt = b;
				return;
			end
			vc = d1 * d4 - d3 * d2;
			if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
				v = quotient(d1, d1 - d3);
				wt = '{65536 - v, v, 0};
				for (int i = 0; i < 3; i++) pt[i] = a[i] + floor16(ab[i] * v);
				return;
			end
			d5 = dot3(sab, scp);
			d6 = dot3(sac, scp);
			if (d6 >= 0 && d5 <= d6) begin
				wt = '{0, 0, 65536};
				pt = c;
				return;
			end
			vb = d5 * d2 - d1 * d6;
			if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
				w = quotient(d2, d2 - d6);
				wt = '{65536 - w, 0, w};
				for (int i = 0; i < 3; i++) pt[i] = a[i] + floor16(ac[i] * w);
				return;
			end
			va = d3 * d6 - d5 * d4;
			if (va <= 0 && (d4 - d3) >= 0 && (d5 - d6) >= 0) begin
				w = quotient(d4 - d3, (d4 - d3) + (d5 - d6));
				wt = '{0, 65536 - w, w};
				for (int i = 0; i < 3; i++) pt[i] = b[i] + floor16(bc[i] * w);
				return;
			end
			den = floor16(va) + floor16(vb) + floor16(vc);
			v = quotient(floor16(vb), den);
			w = quotient(floor16(vc), den);
			wa = 65536 - v - w;
			if (wa < 0) wa = 0;
			wt = '{wa, v, w};
			for (int i = 0; i < 3; i++)
				pt[i] = a[i] + floor16(ab[i] * v) + floor16(ac[i] * w);
		endfunction

		function void note_item(item_t it);
			longint p[3], wt[3], pt[3], o[3], bw[3], bo[3];
			if (it.operation == OP_LOAD) begin
				if (it.corner <= CORNER_LAST) begin
					corner_mem[it.tri_slot][it.corner][0] = longint'(it.coord_x);
					corner_mem[it.tri_slot][it.corner][1] = longint'(it.coord_y);
					corner_mem[it.tri_slot][it.corner][2] = longint'(it.coord_z);
				end
				return;
			end
			begin
				result_t r;
				longint unsigned sq_d, best_d;
				int n;
				bit hit;
				p = '{longint'(it.coord_x), longint'(it.coord_y), longint'(it.coord_z)};
				bw = '{0, 0, 0};
				bo = '{0, 0, 0};
				n = (count < NTRI) ? count : NTRI;
				hit = 0;
				best_d = 0;
				r = '0;
				for (int t = 0; t < n; t++) begin
					nearest_on_tri(p, t, wt, pt);
					sq_d = 0;
					for (int i = 0; i < 3; i++) begin
						o[i] = clamp32(p[i] - pt[i]);
						sq_d += longint'(o[i] * o[i]) >> 16;
					end
					if (!hit || sq_d < best_d) begin
						hit = 1;
						best_d = sq_d;
						r.best_tri = t[7:0];
						bw = wt;
						bo = o;
					end
				end
				r.found = hit;
				r.weight_a = bw[0][16:0];
				r.weight_b = bw[1][16:0];
				r.weight_c = bw[2][16:0];
				r.offset_x = bo[0][31:0];
				r.offset_y = bo[1][31:0];
				r.offset_z = bo[2][31:0];
				pending.push_back(r);
			end
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.found !== e.found) begin
				$error("found exp %0d got %0d", e.found, got.found); errors++;
			end
			if (got.best_tri !== e.best_tri) begin
				$error("best_tri exp %0d got %0d", e.best_tri, got.best_tri); errors++;
			end
			if (got.weight_a !== e.weight_a) begin
				$error("weight_a exp %0d got %0d", e.weight_a, got.weight_a); errors++;
			end
			if (got.weight_b !== e.weight_b) begin
				$error("weight_b exp %0d got %0d", e.weight_b, got.weight_b); errors++;
			end
			if (got.weight_c !== e.weight_c) begin
				$error("weight_c exp %0d got %0d", e.weight_c, got.weight_c); errors++;
			end
			if (got.offset_x !== e.offset_x) begin
				$error("offset_x exp %0d got %0d", e.offset_x, got.offset_x); errors++;
			end
			if (got.offset_y !== e.offset_y) begin
				$error("offset_y exp %0d got %0d", e.offset_y, got.offset_y); errors++;
			end
			if (got.offset_z !== e.offset_z) begin
				$error("offset_z exp %0d got %0d", e.offset_z, got.offset_z); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, cfg_valid, cfg_ready, result_valid;
	logic [8:0] cfg_data;
	item_t item;
	result_t result;

	nearest_board board;
	int idle_pct;
	int queries;

	nearest_triangle_point_search dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .result(result)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) board.check_result(result);
	end

	task automatic send_item(item_t it);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_item(it);
		if (it.operation == OP_QUERY) queries++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_count(int unsigned n);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= n[8:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.count = n;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(40)) - 20) <<< 16;
			default: return 32'($signed($urandom_range(2000000)) - 1000000);
		endcase
	endfunction

	task automatic load_tri(int slot, int mode);
		item_t it;
		for (int c = 0; c < 3; c++) begin
			it.operation = OP_LOAD;
			it.tri_slot = slot[7:0];
			it.corner = c[1:0];
			it.coord_x = rand_coord(mode);
			it.coord_y = rand_coord(mode);
			it.coord_z = rand_coord(mode);
			send_item(it);
		end
	endtask

	task automatic query(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		item_t it;
		it = '0;
		it.operation = OP_QUERY;
		it.tri_slot = 8'($urandom);
		it.corner = 2'($urandom);
		it.coord_x = x;
		it.coord_y = y;
		it.coord_z = z;
		send_item(it);
	endtask

	initial begin
		item_t it;
		board = new();
		queries = 0;
		idle_pct = 0;
		start = 0;
		item = '0;
		cfg_valid = 0;
		cfg_data = '0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty search
		query(32'h7fffffff, 32'h80000000, 32'h0);
		// fixed triangle with corners on the x and y axes, probes of every region
		for (int c = 0; c < 3; c++) begin
			it = '0;
			it.operation = OP_LOAD;
			it.corner = c[1:0];
			if (c == 1) it.coord_x = 32'sh40000;
			if (c == 2) it.coord_y = 32'sh40000;
			send_item(it);
		end
		// degenerate: all corners equal, zero edge vectors
		for (int c = 0; c < 3; c++) begin
			it = '0;
			it.operation = OP_LOAD;
			it.tri_slot = 8'd1;
			it.corner = c[1:0];
			it.coord_x = 32'sh10000;
			send_item(it);
		end
		// ignored corner value and extreme coordinates in slot 2
		it = '0;
		it.operation = OP_LOAD;
		it.tri_slot = 8'd2;
		it.corner = 2'd3;
		it.coord_x = 32'h7fffffff;
		send_item(it);
		for (int c = 0; c < 3; c++) begin
			it = '0;
			it.operation = OP_LOAD;
			it.tri_slot = 8'd2;
			it.corner = c[1:0];
			it.coord_x = (c == 0) ? 32'h80000000 : 32'h7fffffff;
			it.coord_y = (c == 2) ? 32'h80000000 : 32'h7fffffff;
			it.coord_z = 32'hffffffff;
			send_item(it);
		end
		set_count(1);
		query(-32'sh10000, -32'sh10000, 0);
		query(32'sh50000, 0, 0);
		query(0, 32'sh50000, 0);
		query(32'sh20000, -32'sh10000, 0);
		query(-32'sh10000, 32'sh20000, 32'sh1000);
		query(32'sh30000, 32'sh30000, 0);
		query(32'sh10000, 32'sh10000, 32'sh30000);
		set_count(3);
		query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		query(32'h80000000, 32'h80000000, 32'h80000000);
		query(32'sh10000, 0, 0);

		// fill slots up to the largest count used below
		for (int s = 3; s < 12; s++) load_tri(s, $urandom_range(2));
		set_count(12);
		query($urandom, $urandom, $urandom);
		set_count(0);
		query($urandom, $urandom, $urandom);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 2) ? 0 : (ph == 1) ? 52 : 34;
			for (int k = 0; k < 7; k++) begin
				if ($urandom_range(3) == 0)
					load_tri($urandom_range(NTRI - 1), $urandom_range(2));
				if ($urandom_range(7) == 0) begin
					it.operation = OP_LOAD;
					it.tri_slot = 8'($urandom);
					it.corner = 2'd3;
					it.coord_x = $urandom;
					it.coord_y = $urandom;
					it.coord_z = $urandom;
					send_item(it);
				end
				if (k % 3 == 0) set_count($urandom_range(1, 12));
				query(rand_coord($urandom_range(2)), rand_coord($urandom_range(2)),
					rand_coord($urandom_range(2)));
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d queries and %0d checked results over several idle mixes",
			queries, board.checked);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

### nearest_triangle_point_search.f
sv/ntps_pkg.sv
sv/ntps_ram.sv
sv/ntps_div.sv
sv/ntps_dp.sv
sv/ntps_ctrl.sv
sv/nearest_triangle_point_search.sv
test/tb.sv
